// ----- hw/rtl/cdq_pkg.sv -----
// shared constants, codes and types for the deque core
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_REAR  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic shift_in;   // push front: take the left neighbour's entry
    logic shift_out;  // pop front: take the right neighbour's entry
    logic load_rear;  // push rear: first empty cell takes the new value
    logic drop_rear;  // pop rear: last occupied cell empties
  } cdq_cmd_t;

endpackage

// ----- hw/rtl/cdq_cell.sv -----
// one storage cell of the deque row
module cdq_cell
  import cdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_cmd_t          cmd,
  input  logic [DATA_W-1:0] push_value,
  input  logic [DATA_W-1:0] left_data,
  input  logic              left_valid,
  input  logic [DATA_W-1:0] right_data,
  input  logic              right_valid,
  output logic [DATA_W-1:0] data,
  output logic              valid,
  output logic [DATA_W-1:0] rear_data
);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;
  logic              is_rear;

  // last occupied cell of the row
  assign is_rear = valid_r & ~right_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.shift_in) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (cmd.shift_out) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (cmd.load_rear) begin
      if (!valid_r && left_valid) begin
        data_nxt  = push_value;
        valid_nxt = 1'b1;
      end
    end else if (cmd.drop_rear) begin
      if (is_rear) valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign valid     = valid_r;
  assign rear_data = is_rear ? data_r : '0;

endmodule

// ----- hw/rtl/circular_deque_core.sv -----
// deque core: a row of shifting cells with front at cell 0 and rear at the last valid cell
// latency: the result of a beat taken at one edge is shown with out_valid in the next cycle
// throughput: one operation every cycle, busy never rises; each op is one row update
// the receiver cannot stall, so every result shows for exactly one cycle
// reset (rst_n low, synchronous) empties the queue: cell valid bits and count clear
// cell data are not reset and are only read once written
module circular_deque_core
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_pop_value,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_occupancy
);

  // row wiring: one slot per cell, neighbours at the ends are tied off below
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_valid [DEPTH];
  logic [DATA_W-1:0] cell_rear  [DEPTH];

  logic              accept;
  logic              full, empty;
  logic              is_push;
  cdq_cmd_t          cmd;
  logic [DATA_W-1:0] rear_value;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_pop_value_r, out_pop_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  // one beat per cycle, the core never holds the sender off
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign is_push = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_PUSH_REAR);

  // decode the beat into a row command; refused ops leave the row untouched
  always_comb begin
    cmd               = '0;
    cnt_nxt           = cnt_r;
    out_pop_value_nxt = '0;
    out_status_nxt    = ST_DONE;
    if (accept) begin
      if (is_push) begin
        if (full) begin
          out_status_nxt = ST_OVERFLOW;
        end else begin
          cmd.shift_in  = (in_kind == KIND_PUSH_FRONT);
          cmd.load_rear = (in_kind == KIND_PUSH_REAR);
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_status_nxt    = ST_UNDERFLOW;
          out_pop_value_nxt = '1;
        end else begin
          cmd.shift_out     = (in_kind == KIND_POP_FRONT);
          cmd.drop_rear     = (in_kind == KIND_POP_REAR);
          out_pop_value_nxt = (in_kind == KIND_POP_FRONT) ? cell_data[0] : rear_value;
          cnt_nxt           = cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // the row of cells; end neighbours are tied off
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] l_data, r_data;
    logic              l_valid, r_valid;

    if (i == 0) begin : g_first
      // new front value enters here; cell 0 always sees an occupied left side
      assign l_data  = in_push_value;
      assign l_valid = 1'b1;
    end else begin : g_inner_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .push_value  (in_push_value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .rear_data   (cell_rear[i])
    );
  end

  // at most one cell flags itself as rear (none when empty), so an or over the row picks it
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_value = rear_value | cell_rear[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload, only meaningful while out_valid is high
  always_ff @(posedge clk) begin
    out_pop_value_r <= out_pop_value_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = cnt_r;

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// port-level checks for the deque core and their bind
module cdq_checker
  import cdq_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               in_kind,
  input logic signed [DATA_W-1:0] in_push_value,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_pop_value,
  input logic [1:0]               out_status,
  input logic [CNT_W-1:0]         out_occupancy
);

  // every accepted beat gives one result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after accepted beat");

  // no result appears without an accepted beat before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without accepted beat");

  // underflow only on an empty queue and reports minus one
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_UNDERFLOW) |->
      (out_occupancy == '0 && out_pop_value == -32'sd1))
    else $error("bad underflow result");

  // overflow only when full, and a push never returns data
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |->
      (out_occupancy == CNT_W'(DEPTH) && out_pop_value == '0))
    else $error("bad overflow result");

  // a push that is taken while the queue is not full grows the queue by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_PUSH_FRONT || in_kind == KIND_PUSH_REAR)
      && out_occupancy != CNT_W'(DEPTH))
      |=> (out_occupancy == $past(out_occupancy) + CNT_W'(1)))
    else $error("push did not grow queue");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);
